[design/hs_pkg.sv]
// Shared types and constants for the sorting chain.
`default_nettype none

package hs_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] hs_data_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the incoming value in order
        logic shift;  // move every entry one place towards the head
    } hs_ctrl_t;

endpackage

`default_nettype wire

[design/hs_cell.sv]
// One cell of the sorting chain: holds one entry, ordered against its neighbours.
`default_nettype none

module hs_cell
    import hs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire hs_ctrl_t ctrl,
    input  wire hs_data_t in_value,
    input  wire logic     prev_lt,
    input  wire logic     prev_occ,
    input  wire hs_data_t prev_value,
    input  wire logic     next_occ,
    input  wire hs_data_t next_value,
    output logic          lt,
    output logic          occ,
    output hs_data_t      value
);

    logic     occ_reg;
    logic     occ_next;
    hs_data_t value_reg;
    hs_data_t value_next;

    // new entry belongs at or before this cell
    assign lt    = !occ_reg || (in_value < value_reg);
    assign occ   = occ_reg;
    assign value = value_reg;

    always_comb begin
        occ_next   = occ_reg;
        value_next = value_reg;
        if (ctrl.shift) begin
            occ_next   = next_occ;
            value_next = next_value;
        end else if (ctrl.load) begin
            occ_next = occ_reg | prev_occ;
            if (lt) begin
                value_next = prev_lt ? prev_value : in_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

[design/heap_sorter.sv]
// Top level: ascending sorter built from a chain of ordered cells.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata = value, tlast = last_item
//  m_      | out | m_tvalid/m_tready  | tdata = sorted_value, tlast = last_result,
//          |     |                    | tuser = overflow
//
// Loading inserts each accepted item in order across the chain, ready for the next.
// After the transfer marked last, results follow one per cycle while m_tready is high;
// no input is taken until the final result is out.
// Reset empties the chain and clears the count and overflow flag; no clearing pass.
// A stalled result holds at the head of the chain.
`default_nettype none

module heap_sorter
    import hs_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // [31:0] sorted_value
    output logic                   m_tlast,
    output logic                   m_tuser    // [0] overflow
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic             drain_reg, drain_next;

    hs_ctrl_t         ctrl;
    logic [DEPTH-1:0] lt_vec;
    logic [DEPTH-1:0] occ_vec;
    hs_data_t         val_vec [DEPTH];

    logic in_fire;
    logic out_fire;
    logic full;

    assign s_tready = !drain_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));

    assign m_tvalid = drain_reg;
    assign m_tdata  = val_vec[0];
    assign m_tlast  = !occ_vec[1];
    assign m_tuser  = overflow_reg;
    assign out_fire = m_tvalid && m_tready;

    assign ctrl.load  = in_fire && !full;
    assign ctrl.shift = out_fire;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic     p_lt, p_occ, n_occ;
        hs_data_t p_val, n_val;

        if (i == 0) begin : g_head
            assign p_lt  = 1'b0;
            assign p_occ = 1'b1;
            assign p_val = s_tdata;
        end else begin : g_body
            assign p_lt  = lt_vec[i-1];
            assign p_occ = occ_vec[i-1];
            assign p_val = val_vec[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign n_occ = 1'b0;
            assign n_val = val_vec[i];
        end else begin : g_link
            assign n_occ = occ_vec[i+1];
            assign n_val = val_vec[i+1];
        end

        hs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .in_value   (s_tdata),
            .prev_lt    (p_lt),
            .prev_occ   (p_occ),
            .prev_value (p_val),
            .next_occ   (n_occ),
            .next_value (n_val),
            .lt         (lt_vec[i]),
            .occ        (occ_vec[i]),
            .value      (val_vec[i])
        );
    end

    always_comb begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        drain_next    = drain_reg;
        if (in_fire) begin
            if (full) begin
                overflow_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
            if (s_tlast) begin
                drain_next = 1'b1;
            end
        end
        // final transfer of the set returns the block to loading
        if (out_fire && m_tlast) begin
            count_next    = '0;
            overflow_next = 1'b0;
            drain_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            drain_reg    <= 1'b0;
        end else begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            drain_reg    <= drain_next;
        end
    end

`ifndef SYNTHESIS
    a_head_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> occ_vec[0])
        else $error("result offered from an empty head cell");

    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        !drain_reg |-> (CNT_W'($countones(occ_vec)) == count_reg))
        else $error("occupied cells disagree with item count");

    a_empty_after_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_tlast) |=> (occ_vec == '0))
        else $error("chain not empty after final transfer");
`endif

endmodule

`default_nettype wire
